@@ design/assert_macros.svh @@
// assertion macros shared by the compositor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, off while reset is asserted
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also live during reset
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(name, prop, msg)
`define ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

@@ design/fcmp_pkg.sv @@
// shared constants for the front-to-back pixel compositor
package fcmp_pkg;

    // default channel width, unsigned q0.n
    localparam int CHANNEL_BITS_DEF = 16;

    // image size register and pixel index widths
    localparam int PIXCNT_BITS = 21;
    localparam int IDX_BITS    = 20;

    // apb port
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // register map, selected by byte address bit 2
    localparam logic REG_CUTOFF   = 1'b0;
    localparam logic REG_PIXCOUNT = 1'b1;

    // opacity cutoff reset value is 0.99 of full scale
    localparam int CUTOFF_NUM = 99;
    localparam int CUTOFF_DEN = 100;

    // pixel count after reset
    localparam logic [PIXCNT_BITS-1:0] PIXCOUNT_RESET = PIXCNT_BITS'(1);

endpackage

@@ design/fcmp_cfg.sv @@
// apb configuration registers: opacity cutoff and pixel count
module fcmp_cfg #(
    parameter int CHANNEL_BITS = fcmp_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fcmp_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [fcmp_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [fcmp_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output logic [CHANNEL_BITS-1:0]              cutoff,
    output logic [fcmp_pkg::PIXCNT_BITS-1:0]     pixel_count
);

    localparam logic [CHANNEL_BITS-1:0] CUTOFF_RESET =
        CHANNEL_BITS'((fcmp_pkg::CUTOFF_NUM * (1 << CHANNEL_BITS)) / fcmp_pkg::CUTOFF_DEN);

    logic [CHANNEL_BITS-1:0]          cutoff_reg;
    logic [fcmp_pkg::PIXCNT_BITS-1:0] pixcount_reg;
    logic                             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg   <= CUTOFF_RESET;
            pixcount_reg <= fcmp_pkg::PIXCOUNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                fcmp_pkg::REG_CUTOFF:   cutoff_reg   <= pwdata[CHANNEL_BITS-1:0];
                fcmp_pkg::REG_PIXCOUNT: pixcount_reg <= pwdata[fcmp_pkg::PIXCNT_BITS-1:0];
                default:                cutoff_reg   <= cutoff_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (paddr[2])
            fcmp_pkg::REG_CUTOFF:   prdata = fcmp_pkg::APB_DATA_BITS'(cutoff_reg);
            fcmp_pkg::REG_PIXCOUNT: prdata = fcmp_pkg::APB_DATA_BITS'(pixcount_reg);
            default:                prdata = '0;
        endcase
    end

    assign cutoff      = cutoff_reg;
    assign pixel_count = pixcount_reg;

endmodule

@@ design/fcmp_blend.sv @@
// one front-to-back blend step: weighted color and opacity accumulation
module fcmp_blend #(
    parameter int CHANNEL_BITS = fcmp_pkg::CHANNEL_BITS_DEF
) (
    input  logic [CHANNEL_BITS-1:0] sum_red,
    input  logic [CHANNEL_BITS-1:0] sum_green,
    input  logic [CHANNEL_BITS-1:0] sum_blue,
    input  logic [CHANNEL_BITS-1:0] sum_opacity,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    input  logic [CHANNEL_BITS-1:0] opacity,
    input  logic [CHANNEL_BITS-1:0] cutoff,
    output logic [CHANNEL_BITS-1:0] next_red,
    output logic [CHANNEL_BITS-1:0] next_green,
    output logic [CHANNEL_BITS-1:0] next_blue,
    output logic [CHANNEL_BITS-1:0] next_opacity
);

    localparam int W = CHANNEL_BITS;

    logic         take;
    logic [W:0]   weight;
    logic [W-1:0] term_red;
    logic [W-1:0] term_green;
    logic [W-1:0] term_blue;
    logic [W-1:0] term_opacity;
    logic [W-1:0] opacity_sum;

    // value times weight, scaled back to q0.w with truncation
    function automatic logic [W-1:0] weighted(input logic [W-1:0] value,
                                              input logic [W:0]   wgt);
        logic [2*W:0] prod;
        prod = {{(W+1){1'b0}}, value} * {{W{1'b0}}, wgt};
        return prod[2*W-1:W];
    endfunction

    // add with saturation at full scale
    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a,
                                             input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[W] ? {W{1'b1}} : s[W-1:0];
    endfunction

    // remaining transparency of the pixel
    assign take   = sum_opacity < cutoff;
    assign weight = {1'b1, {W{1'b0}}} - {1'b0, sum_opacity};

    // one multiplier per channel
    assign term_red     = weighted(red, weight);
    assign term_green   = weighted(green, weight);
    assign term_blue    = weighted(blue, weight);
    assign term_opacity = weighted(opacity, weight);

    // opacity cannot pass full scale, the weight keeps it below one
    assign opacity_sum = sum_opacity + term_opacity;

    // fragments past the cutoff leave the sums alone
    assign next_red     = take ? sat_add(sum_red, term_red)     : sum_red;
    assign next_green   = take ? sat_add(sum_green, term_green) : sum_green;
    assign next_blue    = take ? sat_add(sum_blue, term_blue)   : sum_blue;
    assign next_opacity = take ? opacity_sum                    : sum_opacity;

endmodule

@@ design/fcmp_pixcnt.sv @@
// pixel position counter that flags the final pixel of an image
module fcmp_pixcnt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [fcmp_pkg::PIXCNT_BITS-1:0] pixel_count,
    output logic                             last_pixel
);

    logic [fcmp_pkg::IDX_BITS-1:0]    idx_reg;
    logic [fcmp_pkg::IDX_BITS-1:0]    idx_next;
    logic [fcmp_pkg::PIXCNT_BITS-1:0] count_eff;
    logic [fcmp_pkg::PIXCNT_BITS-1:0] limit;

    // a count of zero acts as one
    assign count_eff  = (pixel_count == '0) ? fcmp_pkg::PIXCNT_BITS'(1) : pixel_count;
    assign limit      = count_eff - fcmp_pkg::PIXCNT_BITS'(1);
    assign last_pixel = fcmp_pkg::PIXCNT_BITS'(idx_reg) >= limit;

    // wrap on the final pixel, else count up
    always_comb
    begin
        idx_next = idx_reg;
        if (step)
        begin
            idx_next = last_pixel ? '0 : idx_reg + fcmp_pkg::IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ design/front_to_back_pixel_compositor.sv @@
// top level of the front-to-back pixel compositor
//
// Fragments enter on the frag channel (frag_valid / frag_stall), nearest
// first, one transaction per fragment; last_layer closes the pixel.
// Composited pixels leave on the pix channel (pix_valid / pix_stall), one
// transaction per last_layer fragment, with last_pixel set on the final
// pixel of the image. Configuration goes through the apb port: byte 0
// holds the opacity cutoff, byte 4 the pixel count of an image.
// Path: a fragment is registered in the input register when accepted; a
// closing fragment's blend is then captured in the output register, which
// raises pix_valid, unless an untaken pixel stalls it; other fragments are
// blended into the accumulators.
// Throughput: one fragment per cycle while frag_stall is low, set by the
// accumulator loop of one multiply per channel and one saturating add per color.
// While pix_stall holds a finished pixel, fragments that close no pixel
// keep flowing; a second closing fragment waits in the input register and
// frag_stall rises until the output is taken.
// Reset clears the accumulators, the pixel index and both valids, and
// loads the cutoff with 0.99 and the pixel count with one.
`include "assert_macros.svh"

module front_to_back_pixel_compositor #(
    parameter int CHANNEL_BITS = fcmp_pkg::CHANNEL_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // apb configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fcmp_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [fcmp_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [fcmp_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    // fragment channel
    input  logic                               frag_valid,
    output logic                               frag_stall,
    input  logic [CHANNEL_BITS-1:0]            red,
    input  logic [CHANNEL_BITS-1:0]            green,
    input  logic [CHANNEL_BITS-1:0]            blue,
    input  logic [CHANNEL_BITS-1:0]            opacity,
    input  logic                               last_layer,
    // pixel channel
    output logic                               pix_valid,
    input  logic                               pix_stall,
    output logic [CHANNEL_BITS-1:0]            out_red,
    output logic [CHANNEL_BITS-1:0]            out_green,
    output logic [CHANNEL_BITS-1:0]            out_blue,
    output logic                               last_pixel
);

    logic [CHANNEL_BITS-1:0]          cutoff;
    logic [fcmp_pkg::PIXCNT_BITS-1:0] pixel_count;

    // input register
    logic                    frag_valid_reg;
    logic                    frag_valid_next;
    logic [CHANNEL_BITS-1:0] red_reg;
    logic [CHANNEL_BITS-1:0] green_reg;
    logic [CHANNEL_BITS-1:0] blue_reg;
    logic [CHANNEL_BITS-1:0] opacity_reg;
    logic                    last_reg;

    // accumulators
    logic [CHANNEL_BITS-1:0] sum_red_reg;
    logic [CHANNEL_BITS-1:0] sum_green_reg;
    logic [CHANNEL_BITS-1:0] sum_blue_reg;
    logic [CHANNEL_BITS-1:0] sum_opacity_reg;
    logic [CHANNEL_BITS-1:0] blend_red;
    logic [CHANNEL_BITS-1:0] blend_green;
    logic [CHANNEL_BITS-1:0] blend_blue;
    logic [CHANNEL_BITS-1:0] blend_opacity;

    // output register
    logic                    pix_valid_reg;
    logic                    pix_valid_next;
    logic [CHANNEL_BITS-1:0] out_red_reg;
    logic [CHANNEL_BITS-1:0] out_green_reg;
    logic [CHANNEL_BITS-1:0] out_blue_reg;
    logic                    last_pixel_reg;

    logic frag_accept;
    logic out_free;
    logic blend_go;
    logic pixel_done;
    logic final_px;

    fcmp_cfg #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cutoff      (cutoff),
        .pixel_count (pixel_count)
    );

    fcmp_blend #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_blend (
        .sum_red      (sum_red_reg),
        .sum_green    (sum_green_reg),
        .sum_blue     (sum_blue_reg),
        .sum_opacity  (sum_opacity_reg),
        .red          (red_reg),
        .green        (green_reg),
        .blue         (blue_reg),
        .opacity      (opacity_reg),
        .cutoff       (cutoff),
        .next_red     (blend_red),
        .next_green   (blend_green),
        .next_blue    (blend_blue),
        .next_opacity (blend_opacity)
    );

    fcmp_pixcnt u_pixcnt (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (pixel_done),
        .pixel_count (pixel_count),
        .last_pixel  (final_px)
    );

    // handshake: a registered fragment blends unless it closes a pixel
    // while the output still holds an untaken one
    assign out_free    = !pix_valid_reg || !pix_stall;
    assign blend_go    = frag_valid_reg && (!last_reg || out_free);
    assign pixel_done  = blend_go && last_reg;
    assign frag_stall  = frag_valid_reg && !blend_go;
    assign frag_accept = frag_valid && !frag_stall;

    always_comb
    begin
        frag_valid_next = frag_valid_reg;
        if (frag_accept)
        begin
            frag_valid_next = 1'b1;
        end
        else if (blend_go)
        begin
            frag_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        if (pixel_done)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix_valid_reg && !pix_stall)
        begin
            pix_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_valid_reg  <= 1'b0;
            pix_valid_reg   <= 1'b0;
            sum_red_reg     <= '0;
            sum_green_reg   <= '0;
            sum_blue_reg    <= '0;
            sum_opacity_reg <= '0;
        end
        else
        begin
            frag_valid_reg <= frag_valid_next;
            pix_valid_reg  <= pix_valid_next;
            if (pixel_done)
            begin
                sum_red_reg     <= '0;
                sum_green_reg   <= '0;
                sum_blue_reg    <= '0;
                sum_opacity_reg <= '0;
            end
            else if (blend_go)
            begin
                sum_red_reg     <= blend_red;
                sum_green_reg   <= blend_green;
                sum_blue_reg    <= blend_blue;
                sum_opacity_reg <= blend_opacity;
            end
        end
    end

    // input payload capture
    always_ff @(posedge clk)
    begin
        if (frag_accept)
        begin
            red_reg     <= red;
            green_reg   <= green;
            blue_reg    <= blue;
            opacity_reg <= opacity;
            last_reg    <= last_layer;
        end
    end

    // output payload capture
    always_ff @(posedge clk)
    begin
        if (pixel_done)
        begin
            out_red_reg    <= blend_red;
            out_green_reg  <= blend_green;
            out_blue_reg   <= blend_blue;
            last_pixel_reg <= final_px;
        end
    end

    assign pix_valid  = pix_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign last_pixel = last_pixel_reg;

    // checks
    `ASSERT_CLK(a_sums_cleared, pixel_done |=> (sum_opacity_reg == '0 && sum_red_reg == '0), "accumulators not cleared after a pixel")
    `ASSERT_CLK(a_opacity_rises, (blend_go && !last_reg) |=> (sum_opacity_reg >= $past(sum_opacity_reg)), "accumulated opacity fell within a pixel")
    `ASSERT_ALWAYS(a_stall_cause, frag_stall |-> (frag_valid_reg && last_reg && pix_valid_reg && pix_stall), "fragment stall without a blocked pixel")

endmodule

@@ test/front_to_back_pixel_compositor_tb.sv @@
// self-checking testbench for the front-to-back pixel compositor
module front_to_back_pixel_compositor_tb;

    localparam int CH = fcmp_pkg::CHANNEL_BITS_DEF;
    localparam int CNT_BITS = fcmp_pkg::PIXCNT_BITS;
    localparam int AW = fcmp_pkg::APB_ADDR_BITS;
    localparam int DW = fcmp_pkg::APB_DATA_BITS;

    localparam logic [AW-1:0] ADDR_CUTOFF   = {fcmp_pkg::REG_CUTOFF, 2'b00};
    localparam logic [AW-1:0] ADDR_PIXCOUNT = {fcmp_pkg::REG_PIXCOUNT, 2'b00};

    // 0.99 of full scale, truncated
    localparam int CUTOFF_RESET = ((1 << CH) * fcmp_pkg::CUTOFF_NUM) / fcmp_pkg::CUTOFF_DEN;
    localparam logic [CH-1:0] FULL = '1;

    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SEG_ITEMS    = 150;

    typedef struct packed {
        logic [CH-1:0] red;
        logic [CH-1:0] green;
        logic [CH-1:0] blue;
        logic [CH-1:0] opacity;
        logic          last_layer;
    } frag_t;

    typedef struct packed {
        logic [CH-1:0] red;
        logic [CH-1:0] green;
        logic [CH-1:0] blue;
        logic          last_pixel;
    } pixel_t;

    // compositing predictor and store of expected pixels
    class pixel_scoreboard;
        bit [CH-1:0]                  cutoff;
        bit [CNT_BITS-1:0]            pix_count;
        bit [CH-1:0]                  acc_red;
        bit [CH-1:0]                  acc_green;
        bit [CH-1:0]                  acc_blue;
        bit [CH-1:0]                  acc_opacity;
        bit [fcmp_pkg::IDX_BITS-1:0]  pix_index;
        pixel_t                       expected_pixels[$];
        int                           errors;

        function new();
            cutoff      = CH'(CUTOFF_RESET);
            pix_count   = fcmp_pkg::PIXCOUNT_RESET;
            acc_red     = '0;
            acc_green   = '0;
            acc_blue    = '0;
            acc_opacity = '0;
            pix_index   = '0;
            errors      = 0;
        endfunction

        // value times weight, truncated back to q0.n
        function bit [CH-1:0] scaled(bit [CH-1:0] value, bit [CH:0] weight);
            bit [2*CH:0] prod;
            prod = value * weight;
            return prod[2*CH-1:CH];
        endfunction

        function bit [CH-1:0] sat_sum(bit [CH-1:0] a, bit [CH-1:0] b);
            bit [CH:0] s;
            s = a + b;
            return s[CH] ? FULL : s[CH-1:0];
        endfunction

        // blend one accepted fragment, queue a pixel on the closing one
        function void note_fragment(frag_t f);
            bit [CH:0]         weight;
            bit [CNT_BITS-1:0] eff_count;
            pixel_t            px;
            if (acc_opacity < cutoff)
            begin
                weight      = {1'b1, {CH{1'b0}}} - {1'b0, acc_opacity};
                acc_red     = sat_sum(acc_red, scaled(f.red, weight));
                acc_green   = sat_sum(acc_green, scaled(f.green, weight));
                acc_blue    = sat_sum(acc_blue, scaled(f.blue, weight));
                acc_opacity = acc_opacity + scaled(f.opacity, weight);
            end
            if (f.last_layer)
            begin
                eff_count     = (pix_count == 0) ? CNT_BITS'(1) : pix_count;
                px.red        = acc_red;
                px.green      = acc_green;
                px.blue       = acc_blue;
                px.last_pixel = ({1'b0, pix_index} >= eff_count - 1);
                pix_index     = px.last_pixel ? '0 : pix_index + 1'b1;
                expected_pixels.push_back(px);
                acc_red       = '0;
                acc_green     = '0;
                acc_blue      = '0;
                acc_opacity   = '0;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare a delivered pixel with the oldest expected one
        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: pixel %h delivered with none expected", $time, got);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("out_red", want.red, got.red);
            compare_field("out_green", want.green, got.green);
            compare_field("out_blue", want.blue, got.blue);
            compare_field("last_pixel", want.last_pixel, got.last_pixel);
        endfunction

        function void write_register(logic [AW-1:0] addr, bit [DW-1:0] value);
            case (addr)
                ADDR_CUTOFF:   cutoff = value[CH-1:0];
                ADDR_PIXCOUNT: pix_count = value[CNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function bit [DW-1:0] register_value(logic [AW-1:0] addr);
            case (addr)
                ADDR_CUTOFF:   return DW'(cutoff);
                ADDR_PIXCOUNT: return DW'(pix_count);
                default:       return '0;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    // dut signals; the inputs are all known from time zero
    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [DW-1:0] pwdata = '0;
    logic [DW-1:0] prdata;
    logic          pready;
    logic          frag_valid = 1'b0;
    logic          frag_stall;
    logic [CH-1:0] red = '0;
    logic [CH-1:0] green = '0;
    logic [CH-1:0] blue = '0;
    logic [CH-1:0] opacity = '0;
    logic          last_layer = 1'b0;
    logic          pix_valid;
    logic          pix_stall = 1'b0;
    logic [CH-1:0] out_red;
    logic [CH-1:0] out_green;
    logic [CH-1:0] out_blue;
    logic          last_pixel;

    pixel_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;
    int unsigned cycle_count = 0;
    int          items_sent = 0;

    front_to_back_pixel_compositor u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .frag_valid (frag_valid),
        .frag_stall (frag_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .opacity    (opacity),
        .last_layer (last_layer),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .last_pixel (last_pixel)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("front_to_back_pixel_compositor test failed");
            $finish;
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            pix_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            pix_stall <= 1'b1;
        end
        else
            pix_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frag_valid && !frag_stall)
                sb.note_fragment({red, green, blue, opacity, last_layer});
            if (pix_valid && !pix_stall)
                sb.check_pixel({out_red, out_green, out_blue, last_pixel});
        end
    end

    // one apb transfer, select left high for a following transfer
    task automatic apb_access(input logic write, input logic [AW-1:0] addr,
                              input logic [DW-1:0] wdata, output logic [DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
    endtask

    task automatic check_register(input logic [AW-1:0] addr);
        logic [DW-1:0] rd;
        apb_access(1'b0, addr, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== sb.register_value(addr))
        begin
            $display("%0t: register %h readback, expected %h actual %h",
                     $time, addr, sb.register_value(addr), rd);
            sb.errors++;
        end
    endtask

    // write a register and read it back
    task automatic configure(input logic [AW-1:0] addr, input logic [DW-1:0] value);
        logic [DW-1:0] rd;
        apb_access(1'b1, addr, value, rd);
        sb.write_register(addr, value);
        check_register(addr);
    endtask

    // let every expected pixel out and the pipeline settle; the first clock
    // wait makes sure the monitor has noted the last accepted fragment
    task automatic wait_drained();
        frag_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // offer one fragment until accepted, after a random idle gap
    task automatic send_fragment(input frag_t f);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            frag_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frag_valid <= 1'b1;
        red        <= f.red;
        green      <= f.green;
        blue       <= f.blue;
        opacity    <= f.opacity;
        last_layer <= f.last_layer;
        do
            @(posedge clk);
        while (frag_stall);
        items_sent++;
    endtask

    task automatic send_directed(input logic [CH-1:0] r, input logic [CH-1:0] g,
                                 input logic [CH-1:0] b, input logic [CH-1:0] o,
                                 input logic last);
        frag_t f;
        f = {r, g, b, o, last};
        send_fragment(f);
    endtask

    function automatic logic [CH-1:0] rand_color();
        case ($urandom_range(7))
            0:       return FULL;
            1:       return '0;
            default: return CH'($urandom);
        endcase
    endfunction

    function automatic logic [CH-1:0] rand_opacity();
        case ($urandom_range(9))
            0:       return '0;
            1:       return FULL;
            2, 3:    return CH'($urandom_range(0, 4095));
            default: return CH'($urandom);
        endcase
    endfunction

    // one pixel of random fragments, mostly shallow, sometimes deep
    task automatic send_pixel();
        int    layers;
        frag_t f;
        layers = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        for (int i = 0; i < layers; i++)
        begin
            f.red        = rand_color();
            f.green      = rand_color();
            f.blue       = rand_color();
            f.opacity    = rand_opacity();
            f.last_layer = (i == layers - 1);
            send_fragment(f);
        end
    endtask

    // main sequence
    initial
    begin
        logic [DW-1:0] cut_val;
        logic [DW-1:0] cnt_val;
        int            seg_start;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 20;
        recv_stall_pct = 74;

        // reset values
        check_register(ADDR_CUTOFF);
        check_register(ADDR_PIXCOUNT);

        // full scale single layer, black single layer
        send_directed(FULL, FULL, FULL, FULL, 1'b1);
        send_directed('0, '0, '0, '0, 1'b1);
        // color overflow saturates
        send_directed(FULL, FULL, FULL, '0, 1'b0);
        send_directed(FULL, FULL, FULL, '0, 1'b1);
        // opaque front layer hits the cutoff, later layers ignored
        send_directed(16'h1234, 16'h5678, 16'h9abc, FULL, 1'b0);
        send_directed(FULL, FULL, FULL, FULL, 1'b0);
        send_directed(FULL, FULL, FULL, FULL, 1'b1);
        // partial opacities blend
        send_directed(16'h8000, 16'h4000, 16'hffff, 16'h8000, 1'b0);
        send_directed(16'h0001, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
        send_directed(16'hffff, 16'h0000, 16'h5555, 16'hc000, 1'b1);
        wait_drained();

        // zero cutoff ignores every fragment
        configure(ADDR_CUTOFF, '0);
        send_directed(FULL, FULL, FULL, FULL, 1'b0);
        send_directed(16'h00ff, 16'hff00, 16'h0f0f, 16'h1000, 1'b1);
        wait_drained();

        // zero pixel count acts as one
        configure(ADDR_CUTOFF, FULL);
        configure(ADDR_PIXCOUNT, '0);
        send_directed(16'haaaa, 16'h5555, 16'h0000, 16'h7777, 1'b1);
        send_directed(16'h5555, 16'haaaa, 16'hffff, 16'hffff, 1'b1);
        wait_drained();

        // index past a shrunk count wraps on the next pixel
        configure(ADDR_PIXCOUNT, 5);
        for (int i = 0; i < 4; i++)
            send_directed(CH'($urandom), CH'($urandom), CH'($urandom), CH'($urandom), 1'b1);
        wait_drained();
        configure(ADDR_PIXCOUNT, 2);
        send_directed(16'h0102, 16'h0304, 16'h0506, 16'h0708, 1'b1);
        wait_drained();

        // random phases, each through several register settings
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 20 : (phase == 1) ? 74 : 0;
            recv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 20 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                case (seg)
                    0: cut_val = CUTOFF_RESET;
                    1: cut_val = $urandom_range(0, 65535);
                    2: cut_val = (phase == 0) ? 0 : (phase == 1) ? FULL : $urandom_range(1, 255);
                    default: cut_val = $urandom_range(60000, 65535);
                endcase
                case (seg)
                    0: cnt_val = $urandom_range(1, 6);
                    1: cnt_val = $urandom_range(0, 1);
                    2: cnt_val = (phase == 0) ? 1048576 : (phase == 1) ? 2097151
                                 : $urandom_range(0, 2097151);
                    default: cnt_val = $urandom_range(2, 40);
                endcase
                configure(ADDR_CUTOFF, cut_val);
                configure(ADDR_PIXCOUNT, cnt_val);

                // long receiver hold-off while fragments keep coming
                if (phase == 2 && seg == 0)
                begin
                    hold_req <= ~hold_req;
                    for (int i = 0; i < 40; i++)
                        send_directed(rand_color(), rand_color(), rand_color(),
                                      rand_opacity(), i[0]);
                end

                seg_start = items_sent;
                while (items_sent - seg_start < SEG_ITEMS)
                    send_pixel();
                wait_drained();
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("front_to_back_pixel_compositor test passed");
        else
            $display("front_to_back_pixel_compositor test failed");
        $finish;
    end

endmodule
